[rtl/assert_macros.svh]
// assertion helpers shared by the rtl modules
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mfct_pkg.sv]
// ----------------------------------------------------------------------------
// mfct_pkg
// shared types and constants of the mouse frame to cursor tracker
// ----------------------------------------------------------------------------
`default_nettype none

package mfct_pkg;

  localparam int COORD_WIDTH_DEF = 12;

  localparam int FRAME_W     = 32;
  localparam int SIZE_W      = 12;
  localparam int PCT_W       = 7;
  localparam int BYTE_W      = 8;
  localparam int OUT_COORD_W = 12;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 12;

  // frame headers and wheel codes
  localparam logic [FRAME_W-1:0] MOUSE_HEADER = 32'h0000_0101;
  localparam logic [BYTE_W-1:0]  KBD_HDR_LO   = 8'h01;
  localparam logic [BYTE_W-1:0]  KBD_HDR_HI   = 8'h00;
  localparam logic [BYTE_W-1:0]  WHEEL_UP     = 8'h01;
  localparam logic [BYTE_W-1:0]  WHEEL_DOWN   = 8'hFF;
  localparam logic [BYTE_W-1:0]  Y_MOST_NEG   = 8'h80;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 8'd3;

  // reset values
  localparam logic [SIZE_W-1:0] SCREEN_W_RST   = 12'd1920;
  localparam logic [SIZE_W-1:0] SCREEN_H_RST   = 12'd1080;
  localparam logic [PCT_W-1:0]  SENS_RST       = 7'd50;
  localparam logic [PCT_W-1:0]  THRESH_RST     = 7'd1;
  localparam int                CURSOR_COL_RST = 960;
  localparam int                CURSOR_ROW_RST = 540;

  // scaling arithmetic
  localparam int MAG_W       = 8;
  localparam int COEFF_W     = 11;
  localparam int SCALED_W    = SIZE_W + 7;
  localparam int SCALE_SHIFT = 8;
  localparam int PROD1_W     = MAG_W + COEFF_W;
  localparam int PROD2_W     = PROD1_W + PCT_W;
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 32;
  localparam int QUO_W       = 12;
  localparam int DIV_W       = 14;

  localparam logic [SCALED_W-1:0] SCALE_NUM = 19'd100;
  localparam logic [DIV_W-1:0]    DIV_CONST = 14'd10000;
  // floor(2^32 / 10000)
  localparam logic [RECIP_W-1:0]  RECIP_M   = 19'd429496;

  typedef struct packed {
    logic capture;
    logic decode;
    logic mul2;
    logic recip;
    logic corr;
    logic update;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic move_req;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/mfct_ctrl.sv]
// ----------------------------------------------------------------------------
// mfct_ctrl
// sequencer for one frame: capture, decode, scale steps, cursor update, output
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mfct_ctrl
  import mfct_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_MUL2   = 3'd2;
  localparam logic [2:0] ST_RECIP  = 3'd3;
  localparam logic [2:0] ST_CORR   = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = sts.move_req ? ST_MUL2 : ST_FINISH;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_RECIP;
      end
      ST_RECIP: begin
        cmd.recip = 1'b1;
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEXT(a_accept_to_decode, in_valid && in_ready, state_r == ST_DECODE, "accept did not start decode")
  `ASSERT_IMPL(a_result_from_finish, $rose(out_valid_r), $past(state_r) == ST_FINISH, "result raised outside finish")

endmodule

`default_nettype wire

[rtl/mfct_datapath.sv]
// ----------------------------------------------------------------------------
// mfct_datapath
// frame registers, config registers, validity filter, two scaling lanes,
// cursor state and output registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mfct_datapath
  import mfct_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dp_cmd_t                cmd,
  output dp_sts_t                     sts,
  input  wire logic [FRAME_W-1:0]     frame_word0,
  input  wire logic [FRAME_W-1:0]     frame_word1,
  input  wire logic [FRAME_W-1:0]     frame_word2,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [BYTE_W-1:0]           button_bits,
  output logic [BYTE_W-1:0]           wheel_step,
  output logic [OUT_COORD_W-1:0]      cursor_x,
  output logic [OUT_COORD_W-1:0]      cursor_y,
  output logic [BYTE_W-1:0]           key_modifier,
  output logic [BYTE_W-1:0]           key_code_0,
  output logic [BYTE_W-1:0]           key_code_1,
  output logic [BYTE_W-1:0]           key_code_2,
  output logic [BYTE_W-1:0]           key_code_3,
  output logic [BYTE_W-1:0]           key_code_4,
  output logic [BYTE_W-1:0]           key_code_5
);

  localparam int SW = COORD_WIDTH + 3;
  localparam logic [SW-1:0] COORD_MAX = SW'((1 << COORD_WIDTH) - 1);

  // frame words
  logic [FRAME_W-1:0] w0_r, w1_r, w2_r;

  // configuration
  logic [SIZE_W-1:0] size_r [2];
  logic [PCT_W-1:0]  sens_r, thresh_r;
  logic [COEFF_W-1:0] coeff_r [2];
  logic [MAG_W-1:0]   dz_r;

  // filter history
  logic [FRAME_W-1:0] last_word_r;
  logic [BYTE_W-1:0]  last_wheel_r, last_btn_r;

  // per-axis lanes, 0 is x and 1 is y
  logic [COORD_WIDTH-1:0] cur_r   [2];
  logic [PROD1_W-1:0]     prod1_r [2];
  logic [PROD2_W-1:0]     prod2_r [2];
  logic [QUO_W-1:0]       q0_r    [2];
  logic [QUO_W-1:0]       q_r     [2];
  logic                   neg_r   [2];

  // decode
  logic [BYTE_W-1:0] btn, xb, yb, wh;
  logic              is_mouse, is_kbd, wheel_chg, idle, moving, take_a, hold, frame_ok;
  logic [MAG_W-1:0]  mag     [2];
  logic [MAG_W-1:0]  eff_mag [2];
  logic              neg     [2];

  // arithmetic
  logic [SCALED_W-1:0]        scaled  [2];
  logic [PROD2_W+RECIP_W-1:0] recip_p [2];
  logic [PROD2_W-1:0]         rem     [2];
  logic [SW-1:0]              hi      [2];
  logic [SIZE_W-1:0]          size_m1 [2];
  logic signed [SW-1:0]       move    [2];
  logic signed [SW-1:0]       sum     [2];
  logic [COORD_WIDTH-1:0]     clamped [2];
  logic [COORD_WIDTH+OUT_COORD_W-1:0] cur_ext [2];

  assign btn = w1_r[31:24];
  assign xb  = w1_r[23:16];
  assign yb  = w1_r[15:8];
  assign wh  = w1_r[7:0];

  assign is_mouse  = (w0_r == MOUSE_HEADER);
  assign is_kbd    = (w0_r[7:0] == KBD_HDR_LO) && (w0_r[15:8] == KBD_HDR_HI);
  assign wheel_chg = (wh != last_wheel_r);
  assign idle      = (w1_r == '0);
  assign moving    = (xb != '0) || (yb != '0);
  assign take_a    = !idle && (w1_r != last_word_r) && (moving || wheel_chg);
  assign hold      = (last_btn_r == btn) && (btn != '0);
  assign frame_ok  = is_mouse && (take_a || (!hold && wheel_chg));

  // magnitude of the signed offsets, 0x80 reads as 128
  assign mag[0] = xb[7] ? (~xb + 8'd1) : xb;
  assign mag[1] = yb[7] ? (~yb + 8'd1) : yb;
  // y is flipped, except the most negative value which keeps its sign
  assign neg[0] = xb[7];
  assign neg[1] = (yb == Y_MOST_NEG) ? 1'b1 : !yb[7];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      eff_mag[i] = (mag[i] < dz_r) ? '0 : mag[i];
      scaled[i]  = {{(SCALED_W-SIZE_W){1'b0}}, size_r[i]} * SCALE_NUM;
      recip_p[i] = {{RECIP_W{1'b0}}, prod2_r[i]} * {{PROD2_W{1'b0}}, RECIP_M};
      rem[i]     = prod2_r[i]
                 - ({{(PROD2_W-QUO_W){1'b0}}, q0_r[i]} * {{(PROD2_W-DIV_W){1'b0}}, DIV_CONST});
      // clamp bound: zero for a zero size, never past the coordinate range
      size_m1[i] = (size_r[i] == '0) ? '0 : size_r[i] - 12'd1;
      hi[i]      = {{(SW-SIZE_W){1'b0}}, size_m1[i]};
      if (hi[i] > COORD_MAX) begin
        hi[i] = COORD_MAX;
      end
      move[i] = signed'({{(SW-QUO_W){1'b0}}, q_r[i]});
      if (neg_r[i]) begin
        move[i] = -move[i];
      end
      sum[i] = signed'({3'b000, cur_r[i]}) + move[i];
      if (sum[i] < 0) begin
        clamped[i] = '0;
      end else if (sum[i] > signed'(hi[i])) begin
        clamped[i] = hi[i][COORD_WIDTH-1:0];
      end else begin
        clamped[i] = sum[i][COORD_WIDTH-1:0];
      end
      cur_ext[i] = {{OUT_COORD_W{1'b0}}, cur_r[i]};
    end
  end

  assign sts.move_req = frame_ok && ((eff_mag[0] != '0) || (eff_mag[1] != '0));

  // frame capture and per-step payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w0_r <= frame_word0;
      w1_r <= frame_word1;
      w2_r <= frame_word2;
    end
    for (int i = 0; i < 2; i++) begin
      coeff_r[i] <= scaled[i][SCALE_SHIFT +: COEFF_W];
      if (cmd.decode) begin
        prod1_r[i] <= {{COEFF_W{1'b0}}, eff_mag[i]} * {{MAG_W{1'b0}}, coeff_r[i]};
        neg_r[i]   <= neg[i];
      end
      if (cmd.mul2) begin
        prod2_r[i] <= {{PCT_W{1'b0}}, prod1_r[i]} * {{PROD1_W{1'b0}}, sens_r};
      end
      if (cmd.recip) begin
        q0_r[i] <= recip_p[i][RECIP_SHIFT +: QUO_W];
      end
      if (cmd.corr) begin
        q_r[i] <= (rem[i] >= {{(PROD2_W-DIV_W){1'b0}}, DIV_CONST}) ? q0_r[i] + 12'd1 : q0_r[i];
      end
    end
    dz_r <= {thresh_r, 1'b0};
  end

  // configuration, filter history and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0]    <= SCREEN_W_RST;
      size_r[1]    <= SCREEN_H_RST;
      sens_r       <= SENS_RST;
      thresh_r     <= THRESH_RST;
      last_word_r  <= '0;
      last_wheel_r <= '0;
      last_btn_r   <= '0;
      cur_r[0]     <= COORD_WIDTH'(CURSOR_COL_RST);
      cur_r[1]     <= COORD_WIDTH'(CURSOR_ROW_RST);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCREEN_WIDTH:  size_r[0] <= cfg_data;
          CFG_SCREEN_HEIGHT: size_r[1] <= cfg_data;
          CFG_SENSITIVITY:   sens_r    <= cfg_data[PCT_W-1:0];
          CFG_THRESHOLD:     thresh_r  <= cfg_data[PCT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.decode && frame_ok) begin
        last_word_r  <= w1_r;
        last_wheel_r <= wh;
        last_btn_r   <= btn;
      end
      if (cmd.update) begin
        cur_r[0] <= clamped[0];
        cur_r[1] <= clamped[1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      button_bits  <= is_mouse ? btn : '0;
      wheel_step   <= (is_mouse && ((wh == WHEEL_UP) || (wh == WHEEL_DOWN))) ? wh : '0;
      cursor_x     <= cur_ext[0][OUT_COORD_W-1:0];
      cursor_y     <= cur_ext[1][OUT_COORD_W-1:0];
      key_modifier <= is_kbd ? w1_r[31:24] : '0;
      key_code_0   <= is_kbd ? w1_r[15:8]  : '0;
      key_code_1   <= is_kbd ? w1_r[7:0]   : '0;
      key_code_2   <= is_kbd ? w2_r[31:24] : '0;
      key_code_3   <= is_kbd ? w2_r[23:16] : '0;
      key_code_4   <= is_kbd ? w2_r[15:8]  : '0;
      key_code_5   <= is_kbd ? w2_r[7:0]   : '0;
    end
  end

  `ASSERT_NEXT(a_cursor_only_on_update, !cmd.update,
               $stable(cur_r[0]) && $stable(cur_r[1]), "cursor moved outside update")
  `ASSERT_NEXT(a_cursor_x_clamped, cmd.update, cur_r[0] <= hi[0][COORD_WIDTH-1:0],
               "cursor column past clamp bound")

endmodule

`default_nettype wire

[rtl/mouse_frame_to_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// mouse_frame_to_cursor_tracker
// decodes three-word mouse and keyboard frames and tracks an absolute cursor
// ----------------------------------------------------------------------------
// One frame in, one result out. A header of 0x101 marks a mouse frame: the
// button byte and a filtered wheel byte are reported, a change filter decides
// whether the x/y motion counts, and counted motion is dead-zoned, scaled to
// the screen size and sensitivity, added to the cursor and clamped to the
// screen. A header with low byte 0x01 and next byte 0x00 is a keyboard frame
// and reports the modifier and six key codes. The cursor goes out with every
// result. Frames are handled one at a time: a frame that does not move the
// cursor goes from decode straight to the output step, a frame that moves it
// also runs the scaling sequence (offset times coefficient, times
// sensitivity, reciprocal multiply, remainder correction, add and clamp) that
// runs both axes side by side. A finished result sits in the output register
// while the next frame is taken; the block only waits when a second result is
// ready before the first one was taken. Config writes are always taken and
// should be made while no frame is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_frame_to_cursor_tracker
  import mfct_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // frame transactions
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FRAME_W-1:0]    in_frame_word0,
  input  wire logic [FRAME_W-1:0]    in_frame_word1,
  input  wire logic [FRAME_W-1:0]    in_frame_word2,
  // result transactions
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [BYTE_W-1:0]          out_button_bits,
  output logic [BYTE_W-1:0]          out_wheel_step,
  output logic [OUT_COORD_W-1:0]     out_cursor_x,
  output logic [OUT_COORD_W-1:0]     out_cursor_y,
  output logic [BYTE_W-1:0]          out_key_modifier,
  output logic [BYTE_W-1:0]          out_key_code_0,
  output logic [BYTE_W-1:0]          out_key_code_1,
  output logic [BYTE_W-1:0]          out_key_code_2,
  output logic [BYTE_W-1:0]          out_key_code_3,
  output logic [BYTE_W-1:0]          out_key_code_4,
  output logic [BYTE_W-1:0]          out_key_code_5,
  // register writes: 0 width, 1 height, 2 sensitivity, 3 threshold
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // register writes never stall
  assign cfg_ready = 1'b1;

  mfct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfct_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .frame_word0  (in_frame_word0),
    .frame_word1  (in_frame_word1),
    .frame_word2  (in_frame_word2),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .button_bits  (out_button_bits),
    .wheel_step   (out_wheel_step),
    .cursor_x     (out_cursor_x),
    .cursor_y     (out_cursor_y),
    .key_modifier (out_key_modifier),
    .key_code_0   (out_key_code_0),
    .key_code_1   (out_key_code_1),
    .key_code_2   (out_key_code_2),
    .key_code_3   (out_key_code_3),
    .key_code_4   (out_key_code_4),
    .key_code_5   (out_key_code_5)
  );

endmodule

`default_nettype wire
